>>> rtl/trd_pkg.sv
// Shared types, codes and the slider percent table for the touch report event decoder.
package trd_pkg;

  typedef enum logic [1:0] {
    KIND_SLIDER = 2'd0,
    KIND_LEFT   = 2'd1,
    KIND_POWER  = 2'd2,
    KIND_RIGHT  = 2'd3
  } event_kind_t;

  localparam logic [6:0] CODE_RIGHT = 7'h00;
  localparam logic [6:0] CODE_POWER = 7'h01;
  localparam logic [6:0] CODE_LEFT  = 7'h02;
  localparam logic [6:0] CODE_NONE  = 7'h7F;

  localparam int unsigned PosOffset = 2;
  localparam int unsigned PosSpan   = 53;
  localparam int unsigned PctScale  = 100;

  typedef logic [6:0] pct_table_t [64];

  // percent for each slider offset p, floor(p*100/53); entries above the span are unused
  function automatic pct_table_t build_pct_table();
    pct_table_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 7'((i * PctScale) / PosSpan);
    end
    return t;
  endfunction

  localparam pct_table_t PCT_TABLE = build_pct_table();

endpackage

>>> rtl/touch_report_event_decoder.sv
// Top level of the touch report event decoder: report bytes in, key and slider events out.
//
// Usage
//   in_valid/in_ready carry one report byte per item. out_valid/out_ready carry one
//   event per item: kind, value and a last flag that marks the final event of a report.
//   A report gives zero to three events; zero-event reports only update key and
//   slider state.
// Event path
//   An accepted report is decoded into a pending-event register, and the output
//   register picks its events from there.
// Throughput
//   A report with zero or one event is taken every cycle while out_ready is high. A
//   report with more events holds the pending register until the output register has
//   drained it, one event per cycle while out_ready is high.
// Reset
//   Synchronous, active low: all keys released, last percent zero, nothing pending,
//   out_valid low.
// Stalls
//   With out_ready low the shown event holds. One more decoded report can wait in
//   the pending register; after that in_ready drops until the receiver takes items.
module touch_report_event_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_report_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [6:0] out_event_value,
  output logic       out_last_event
);
  import trd_pkg::*;

  // Key levels: bit 0 left, bit 1 power, bit 2 right.
  logic [2:0]  held_r, held_nxt;
  logic [6:0]  last_pct_r, last_pct_nxt;

  // Pending events: bit 0 single event (press or slider), bits 3:1 releases of
  // left, power, right, drained in that order.
  logic [3:0]  pend_r, pend_nxt;
  event_kind_t single_kind_r, single_kind_nxt;
  logic [6:0]  single_value_r, single_value_nxt;

  logic        out_valid_r, out_valid_nxt;
  event_kind_t out_kind_r, out_kind_nxt;
  logic [6:0]  out_value_r, out_value_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_fire;
  logic        out_adv;
  logic [6:0]  low;
  logic        key_flag;
  logic [5:0]  pos_off;
  logic [6:0]  pct;
  logic [3:0]  new_pend;
  logic [3:0]  pop_sel;
  logic [3:0]  pend_left;

  assign low      = in_report_byte[6:0];
  assign key_flag = in_report_byte[7];

  // output register may load when empty or when its event is taken
  assign out_adv  = !out_valid_r || out_ready;
  // room for a new report once at most one pending event remains and it moves now
  assign in_ready = (pend_r == 4'b0000) || ($onehot(pend_r) && out_adv);
  assign in_fire  = in_valid && in_ready;

  // slider offset; out-of-range positions count as zero
  always_comb begin
    if (low >= 7'(PosOffset) && (low - 7'(PosOffset)) <= 7'(PosSpan)) begin
      pos_off = 6'(low - 7'(PosOffset));
    end else begin
      pos_off = 6'd0;
    end
  end
  assign pct = PCT_TABLE[pos_off];

  // decode of the incoming report against the current key and slider state
  always_comb begin
    new_pend         = 4'b0000;
    held_nxt         = held_r;
    last_pct_nxt     = last_pct_r;
    single_kind_nxt  = single_kind_r;
    single_value_nxt = single_value_r;
    if (low == CODE_NONE) begin
      // no touch: release every held key
      new_pend = {held_r[2], held_r[1], held_r[0], 1'b0};
      held_nxt = 3'b000;
    end else if (key_flag) begin
      case (low)
        CODE_RIGHT: begin
          new_pend[0]      = !held_r[2];
          held_nxt[2]      = 1'b1;
          single_kind_nxt  = KIND_RIGHT;
          single_value_nxt = 7'd1;
        end
        CODE_POWER: begin
          new_pend[0]      = !held_r[1];
          held_nxt[1]      = 1'b1;
          single_kind_nxt  = KIND_POWER;
          single_value_nxt = 7'd1;
        end
        CODE_LEFT: begin
          new_pend[0]      = !held_r[0];
          held_nxt[0]      = 1'b1;
          single_kind_nxt  = KIND_LEFT;
          single_value_nxt = 7'd1;
        end
        default: begin
          // unknown key code: ignored
        end
      endcase
    end else begin
      new_pend[0]      = (pct != last_pct_r);
      last_pct_nxt     = pct;
      single_kind_nxt  = KIND_SLIDER;
      single_value_nxt = pct;
    end
  end

  // pick the next pending event in order: single, left, power, right
  always_comb begin
    pop_sel = 4'b0000;
    if (pend_r[0]) begin
      pop_sel = 4'b0001;
    end else if (pend_r[1]) begin
      pop_sel = 4'b0010;
    end else if (pend_r[2]) begin
      pop_sel = 4'b0100;
    end else if (pend_r[3]) begin
      pop_sel = 4'b1000;
    end
  end
  assign pend_left = pend_r & ~pop_sel;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    if (out_adv) begin
      out_valid_nxt = (pend_r != 4'b0000);
      out_last_nxt  = (pend_left == 4'b0000);
      out_value_nxt = 7'd0;
      case (pop_sel)
        4'b0001: begin
          out_kind_nxt  = single_kind_r;
          out_value_nxt = single_value_r;
        end
        4'b0010: out_kind_nxt = KIND_LEFT;
        4'b0100: out_kind_nxt = KIND_POWER;
        4'b1000: out_kind_nxt = KIND_RIGHT;
        default: out_kind_nxt = out_kind_r;
      endcase
      pend_nxt = pend_left;
    end
    if (in_fire) begin
      pend_nxt = new_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 3'b000;
      last_pct_r  <= 7'd0;
      pend_r      <= 4'b0000;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        held_r     <= held_nxt;
        last_pct_r <= last_pct_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      single_kind_r  <= single_kind_nxt;
      single_value_r <= single_value_nxt;
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_value = out_value_r;
  assign out_last_event  = out_last_r;

  // a report never queues a press or slider event together with releases
  a_pend_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r[0] && (pend_r[3:1] != 3'b000)))
    else $error("single event pending together with releases");

  // a no-touch report leaves all keys released
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_report_byte[6:0] == CODE_NONE) |=> (held_r == 3'b000))
    else $error("keys still held after no-touch report");

  // slider percent stays within 0..100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SLIDER) |-> (out_value_r <= 7'(PctScale)))
    else $error("slider percent out of range");

  // a new report never overwrites pending events that have not moved out
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ((pend_r == 4'b0000) || (out_adv && pend_left == 4'b0000)))
    else $error("pending events lost");

  // key release events carry level zero, presses level one
  a_key_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_SLIDER) |-> (out_value_r <= 7'd1))
    else $error("key event with bad level");

endmodule

>>> tb/sv/trd_event_checker.sv
// Event checker for the touch report event decoder: predicts each report's events and compares.
module trd_event_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_report_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_event_kind,
  input  logic [6:0] out_event_value,
  input  logic       out_last_event,
  output int         mismatch_count,
  output int         events_due,
  output int         events_checked
);
  import trd_pkg::*;

  typedef struct packed {
    event_kind_t kind;
    logic [6:0]  value;
    logic        last;
  } touch_event_t;

  touch_event_t expected_events[$];

  // key levels and last slider percent, mirrored from the block
  logic       left_down;
  logic       power_down;
  logic       right_down;
  logic [6:0] slider_pct;

  task automatic decode_report(input logic [7:0] report);
    touch_event_t batch [3];
    int           n;
    int unsigned  offset;
    logic [6:0]   low;
    logic [6:0]   pct;
    touch_event_t ev;
    n   = 0;
    low = report[6:0];
    if (low == CODE_NONE) begin
      // releases go out left, power, right
      if (left_down) begin
        batch[n] = '{KIND_LEFT, 7'd0, 1'b0};
        n++;
      end
      if (power_down) begin
        batch[n] = '{KIND_POWER, 7'd0, 1'b0};
        n++;
      end
      if (right_down) begin
        batch[n] = '{KIND_RIGHT, 7'd0, 1'b0};
        n++;
      end
      left_down  = 1'b0;
      power_down = 1'b0;
      right_down = 1'b0;
    end else if (report[7]) begin
      case (low)
        CODE_RIGHT: begin
          if (!right_down) begin
            batch[n] = '{KIND_RIGHT, 7'd1, 1'b0};
            n++;
          end
          right_down = 1'b1;
        end
        CODE_POWER: begin
          if (!power_down) begin
            batch[n] = '{KIND_POWER, 7'd1, 1'b0};
            n++;
          end
          power_down = 1'b1;
        end
        CODE_LEFT: begin
          if (!left_down) begin
            batch[n] = '{KIND_LEFT, 7'd1, 1'b0};
            n++;
          end
          left_down = 1'b1;
        end
        default: ;
      endcase
    end else begin
      // out-of-range positions count as offset zero
      offset = 0;
      if (low >= PosOffset && low - PosOffset <= PosSpan) offset = low - PosOffset;
      pct = 7'((offset * PctScale) / PosSpan);
      if (pct != slider_pct) begin
        batch[n] = '{KIND_SLIDER, pct, 1'b0};
        n++;
      end
      slider_pct = pct;
    end
    for (int i = 0; i < n; i++) begin
      ev      = batch[i];
      ev.last = (i == n - 1);
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin : watch
    touch_event_t want;
    if (!rst_n) begin
      left_down      = 1'b0;
      power_down     = 1'b0;
      right_down     = 1'b0;
      slider_pct     = 7'd0;
      mismatch_count = 0;
      events_checked = 0;
      expected_events.delete();
    end else begin
      if (in_valid && in_ready) decode_report(in_report_byte);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event: expected none, got kind %0d value %0d last %0d",
                   $time, out_event_kind, out_event_value, out_last_event);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (out_event_kind !== want.kind) begin
            $display("%0t: event kind: expected %0d, got %0d", $time, want.kind,
                     out_event_kind);
            mismatch_count++;
          end
          if (out_event_value !== want.value) begin
            $display("%0t: event value: expected %0d, got %0d", $time, want.value,
                     out_event_value);
            mismatch_count++;
          end
          if (out_last_event !== want.last) begin
            $display("%0t: last flag: expected %0d, got %0d", $time, want.last,
                     out_last_event);
            mismatch_count++;
          end
        end
      end
    end
    events_due = expected_events.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the touch report event decoder: stimulus, receiver stalls and verdict.
module tb_top;
  import trd_pkg::*;

  // Slowest correct run is roughly 310 reports, each with up to three events behind
  // receiver stalls and sender gaps; the limit leaves a wide margin on top of that.
  localparam int CycleLimit  = 200000;
  // the first event passes the pending and output registers, so SettleCycles of quiet suffice
  localparam int SettleCycles = 8;
  localparam int RandomReports = 286;
  localparam int NumDirected = 24;

  // Directed reports: no touch with nothing held (both flag values), presses including
  // a repeated one, unknown key codes, a release of all three keys, slider at and past
  // both ends of its range, a repeated percent, and a key held across a slider report.
  localparam logic [7:0] DirectedReports [NumDirected] = '{
    {1'b0, CODE_NONE}, {1'b1, CODE_NONE},
    {1'b1, CODE_RIGHT}, {1'b1, CODE_RIGHT}, {1'b1, CODE_POWER}, {1'b1, CODE_LEFT},
    {1'b1, 7'd3}, {1'b1, 7'd126},
    {1'b1, CODE_NONE},
    8'd0, 8'd1, 8'd2, 8'd3, 8'd55, 8'd56, 8'd55, 8'd55, 8'd126, 8'd28,
    {1'b1, CODE_LEFT}, 8'd40, {1'b0, CODE_NONE},
    {1'b1, CODE_POWER}, {1'b1, CODE_NONE}
  };

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_report_byte = 8'h00;
  logic       out_ready      = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_event_kind;
  logic [6:0] out_event_value;
  logic       out_last_event;

  int mismatch_count;
  int events_due;
  int events_checked;

  int cycle_count   = 0;
  int reports_sent  = 0;
  int full_drains   = 0;
  int burst_left    = 0;

  // receiver stall pattern state
  int stall_mode      = 0;
  int stall_mode_left = 0;
  int stall_left      = 0;

  always #4 clk = ~clk;

  touch_report_event_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_report_byte (in_report_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_value(out_event_value),
    .out_last_event (out_last_event)
  );

  trd_event_checker event_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_report_byte (in_report_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_event_value(out_event_value),
    .out_last_event (out_last_event),
    .mismatch_count (mismatch_count),
    .events_due     (events_due),
    .events_checked (events_checked)
  );

  // Watchdog. Any hang in either handshake ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_count, events_due);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: switches between stall styles at random intervals.
  //   0: always ready (no-stall stretches)
  //   1: coin flip each cycle
  //   2: periodic, drops one cycle in three
  //   3: mostly ready with occasional long stalls
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(32, 200);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count % 3 != 0);
      default: begin
        if (stall_left != 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 20);
        end
      end
    endcase
  end

  // Called at a rising edge; returns at the edge where the item is accepted.
  // Bursts of back-to-back items are separated by random gaps with valid low.
  task automatic send_report(input logic [7:0] report);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 48)
                                                : $urandom_range(1, 10);
    end
    in_valid       <= 1'b1;
    in_report_byte <= report;
    // in_ready is settled by the falling edge, so it predicts the next rising edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    burst_left--;
    reports_sent++;
  endtask

  // Hold the sender off until every predicted event has come out.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(negedge clk);
    while (events_due != 0) @(negedge clk);
    @(posedge clk);
    full_drains++;
  endtask

  // Mostly well-formed traffic: presses, no-touch releases and in-range slider
  // positions; the rest is out-of-range positions and unknown key codes.
  function automatic logic [7:0] random_report();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      case ($urandom_range(0, 2))
        0:       return {1'b1, CODE_RIGHT};
        1:       return {1'b1, CODE_POWER};
        default: return {1'b1, CODE_LEFT};
      endcase
    end else if (pick < 50) begin
      return {1'($urandom_range(0, 1)), CODE_NONE};
    end else if (pick < 85) begin
      return {1'b0, 7'($urandom_range(PosOffset, PosOffset + PosSpan))};
    end else if (pick < 94) begin
      if ($urandom_range(0, 3) == 0) return {1'b0, 7'($urandom_range(0, PosOffset - 1))};
      return {1'b0, 7'($urandom_range(PosOffset + PosSpan + 1, 126))};
    end
    return {1'b1, 7'($urandom_range(3, 126))};
  endfunction

  initial begin : stimulus
    logic [7:0] report;
    int         counted;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedReports[i]) send_report(DirectedReports[i]);
    drain_events();

    counted = 0;
    while (counted < RandomReports) begin
      report = random_report();
      send_report(report);
      counted++;
      if ($urandom_range(0, 59) == 0) drain_events();
    end

    drain_events();
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d reports (%0d directed) with %0d events checked and %0d full drains",
             reports_sent, NumDirected, events_checked, full_drains);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
